>>> rtl/assert_macros.svh
// Assertion helper macros for the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion with asynchronous reset disable.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Assertion that a condition never holds.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`endif

>>> rtl/ict_pkg.sv
// ----------------------------------------------------------------------------
// ict_pkg
// Shared types and constants of the co-occurrence toplist core.
// ----------------------------------------------------------------------------
`default_nettype none
package ict_pkg;
  localparam int NumUsers   = 1024;
  localparam int NumItems   = 256;
  localparam int MaxList    = 64;
  localparam int CountWidth = 16;
  localparam int UserW      = $clog2(NumUsers);
  localparam int ItemW      = $clog2(NumItems);
  localparam int CntAddrW   = 2 * ItemW;
  localparam int ListLenW   = 7;
  localparam logic [ListLenW-1:0] ListLenReset = ListLenW'(10);
  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

  typedef enum logic {
    ReqRecord = 1'b0,
    ReqQuery  = 1'b1
  } req_e;

  typedef struct packed {
    logic       req_type;
    logic [9:0] user_id;
    logic [7:0] item_id;
  } req_t;

  typedef struct packed {
    logic [7:0]  source_item;
    logic [7:0]  row_degree;
    logic        has_neighbor;
    logic [7:0]  neighbor_item;
    logic [15:0] weight;
    logic        last;
  } rsp_t;

  typedef enum logic [3:0] {
    StIdle,
    StClear,
    StRecRd,
    StRecWt,
    StRecScan,
    StRecInc,
    StRecWb,
    StQryScan,
    StQryEmit,
    StQryEmpty
  } state_e;
endpackage
`default_nettype wire

>>> rtl/ict_ram.sv
// ----------------------------------------------------------------------------
// ict_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module ict_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

>>> rtl/item_cooccurrence_toplist_core.sv
// ----------------------------------------------------------------------------
// item_cooccurrence_toplist_core
// Co-occurrence counter with per-item top-k neighbour lists.
// ----------------------------------------------------------------------------
// After reset a clearing pass zeroes the count memory and the bitmap
// memory (its 1024 rows are covered within the same pass); busy stays
// high meanwhile. A record keeps busy high until it is done, and ends
// early when the item is already in the user's set: the bitmap row is
// read once, then walked one bit a cycle, but every set bit holds the
// walk for a read-modify-write of both count words through the single
// count memory port. A query walks the count row once per neighbour
// returned, the first walk also counting the degree; an empty row gives
// one result word with no neighbour. Result words come on rsp_valid_o
// for one cycle each and cannot be stalled.
`default_nettype none
`include "assert_macros.svh"
module item_cooccurrence_toplist_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire ict_pkg::req_t req_i,
  output logic               rsp_valid_o,
  output ict_pkg::rsp_t      rsp_o,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [ict_pkg::ListLenW-1:0] cfg_data_i
);
  localparam int IW = ict_pkg::ItemW;
  localparam int AW = ict_pkg::CntAddrW;
  localparam int CW = ict_pkg::CountWidth;
  localparam int UW = ict_pkg::UserW;
  localparam int LW = ict_pkg::ListLenW;

  ict_pkg::state_e state_q, state_d;
  logic [AW:0]   clr_q, clr_d;
  logic [ict_pkg::ListLenW-1:0] len_q;
  logic [IW-1:0] src_q, src_d;      // query item or recorded item
  logic [UW-1:0] usr_q, usr_d;
  logic [IW:0]   j_q, j_d;          // scan index, one wider for end test
  logic [ict_pkg::NumItems-1:0] row_q, row_d;
  logic          dir_q, dir_d;      // 0: [it][j], 1: [j][it]
  logic [8:0]    deg_q, deg_d;
  logic [6:0]    k_q, k_d, lim_q, lim_d;
  logic          first_q, first_d, found_q, found_d, oor_q, oor_d;
  logic [CW-1:0] pc_q, pc_d, bc_q, bc_d;
  logic [IW-1:0] pj_q, pj_d, bj_q, bj_d;
  logic          rd_v_q, rd_v_d;    // read issued last cycle
  logic [IW-1:0] rd_j_q, rd_j_d;

  logic          c_we, b_we;
  logic [AW-1:0] c_addr;
  logic [CW-1:0] c_wdata, c_rdata;
  logic [UW-1:0] b_addr;
  logic [ict_pkg::NumItems-1:0] b_wdata, b_rdata;

  ict_ram #(.Width(CW), .Depth(1 << AW)) u_cnt (
    .clk_i, .we_i(c_we), .addr_i(c_addr), .wdata_i(c_wdata), .rdata_o(c_rdata)
  );
  ict_ram #(.Width(ict_pkg::NumItems), .Depth(ict_pkg::NumUsers)) u_bmp (
    .clk_i, .we_i(b_we), .addr_i(b_addr), .wdata_i(b_wdata), .rdata_o(b_rdata)
  );

  assign cfg_ready_o = 1'b1;
  assign busy = (state_q != ict_pkg::StIdle);

  logic [IW-1:0] jj;
  logic          cand;
  assign jj = j_q[IW-1:0];
  // a count read back is eligible if nonzero and below the previous pick, or equal to it at a higher item
  assign cand = (c_rdata != '0) && (first_q || (c_rdata < pc_q) ||
                (c_rdata == pc_q && rd_j_q > pj_q));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ict_pkg::StIdle: begin
        if (start) begin
          if (req_i.req_type == ict_pkg::ReqQuery) begin
            state_d = ict_pkg::StQryScan;
          end else begin
            state_d = ict_pkg::StRecRd;
          end
        end
      end
      ict_pkg::StClear: if (clr_q[AW]) state_d = ict_pkg::StIdle;
      ict_pkg::StRecRd:   state_d = ict_pkg::StRecWt;
      ict_pkg::StRecWt:   state_d = b_rdata[src_q] ? ict_pkg::StIdle : ict_pkg::StRecScan;
      ict_pkg::StRecScan: begin
        if (j_q[IW]) state_d = ict_pkg::StRecWb;
        else if (row_q[jj] && jj != src_q) state_d = ict_pkg::StRecInc;
      end
      ict_pkg::StRecInc:  state_d = ict_pkg::StRecScan;
      ict_pkg::StRecWb:   state_d = ict_pkg::StIdle;
      ict_pkg::StQryScan: begin
        if (oor_q) state_d = ict_pkg::StQryEmpty;
        else if (j_q[IW] && !rd_v_q) begin
          if (first_q && k_q == '0 && deg_q == '0) state_d = ict_pkg::StQryEmpty;
          else if (k_q != '0 || !first_q) state_d = ict_pkg::StQryEmit;
        end
      end
      ict_pkg::StQryEmit: state_d = (k_q + 7'd1 >= lim_q) ? ict_pkg::StIdle
                                                          : ict_pkg::StQryScan;
      ict_pkg::StQryEmpty: state_d = ict_pkg::StIdle;
      default: state_d = ict_pkg::StIdle;
    endcase
  end

  logic [ict_pkg::ListLenW-1:0] lcl;
  always_comb begin
    lcl = (len_q == '0) ? LW'(1) :
          (len_q > LW'(ict_pkg::MaxList)) ? LW'(ict_pkg::MaxList) : len_q;
  end

  always_comb begin
    clr_d = clr_q; src_d = src_q; usr_d = usr_q; j_d = j_q; row_d = row_q;
    dir_d = dir_q; deg_d = deg_q; k_d = k_q; lim_d = lim_q; first_d = first_q;
    found_d = found_q; oor_d = oor_q; pc_d = pc_q; bc_d = bc_q; pj_d = pj_q;
    bj_d = bj_q; rd_v_d = 1'b0; rd_j_d = rd_j_q;
    c_we = 1'b0; c_addr = {src_q, jj}; c_wdata = '0;
    b_we = 1'b0; b_addr = usr_q; b_wdata = row_q;
    rsp_valid_o = 1'b0;
    rsp_o = '{source_item: src_q, row_degree: (deg_q > 9'd255) ? 8'd255 : deg_q[7:0],
              has_neighbor: 1'b1, neighbor_item: bj_q, weight: bc_q, last: 1'b0};
    case (state_q)
      ict_pkg::StIdle: begin
        src_d = req_i.item_id; usr_d = req_i.user_id; j_d = '0;
        deg_d = '0; k_d = '0; first_d = 1'b1; found_d = 1'b0; dir_d = 1'b0;
        lim_d = lcl; oor_d = 1'b0;
        if (start && req_i.req_type == ict_pkg::ReqRecord) begin
          b_addr = req_i.user_id;
        end
      end
      ict_pkg::StClear: begin
        c_we = 1'b1; c_addr = clr_q[AW-1:0]; clr_d = clr_q + 1'b1;
        b_we = 1'b1; b_addr = clr_q[UW-1:0]; b_wdata = '0;
      end
      ict_pkg::StRecWt: row_d = b_rdata;
      ict_pkg::StRecScan: begin
        if (!j_q[IW]) begin
          if (row_q[jj] && jj != src_q) begin
            c_addr = dir_q ? {jj, src_q} : {src_q, jj};
          end else begin
            j_d = j_q + 1'b1;
          end
        end
      end
      ict_pkg::StRecInc: begin
        c_addr = dir_q ? {jj, src_q} : {src_q, jj};
        c_we = (c_rdata != ict_pkg::CountMax);
        c_wdata = c_rdata + 1'b1;
        dir_d = ~dir_q;
        if (dir_q) j_d = j_q + 1'b1;
      end
      ict_pkg::StRecWb: begin
        b_we = 1'b1; b_wdata = row_q; b_wdata[src_q] = 1'b1;
      end
      ict_pkg::StQryScan: begin
        if (!j_q[IW]) begin
          c_addr = {src_q, jj}; rd_v_d = 1'b1; rd_j_d = jj; j_d = j_q + 1'b1;
        end
        if (rd_v_q) begin
          if (k_q == '0 && first_q && c_rdata != '0) deg_d = deg_q + 1'b1;
          if (cand && (!found_q || c_rdata > bc_q)) begin
            bc_d = c_rdata; bj_d = rd_j_q; found_d = 1'b1;
          end
        end
        if (j_q[IW] && !rd_v_q) begin
          if (first_q && k_q == '0 && found_q) begin
            // degree pass done: clamp the list limit to the degree
            first_d = 1'b0; j_d = '0; found_d = 1'b0; pc_d = '0; pj_d = '0;
            lim_d = (deg_q < 9'(lim_q)) ? deg_q[6:0] : lim_q;
          end
          // the degree pass also picked the best; keep it and skip the rescan
          if (first_q && k_q == '0 && found_q) begin
            found_d = 1'b1; first_d = 1'b0; j_d = 9'(ict_pkg::NumItems);
          end
        end
      end
      ict_pkg::StQryEmit: begin
        rsp_valid_o = 1'b1;
        rsp_o.last = (k_q + 7'd1 >= lim_q);
        k_d = k_q + 7'd1; pc_d = bc_q; pj_d = bj_q; first_d = 1'b0;
        found_d = 1'b0; j_d = '0;
      end
      ict_pkg::StQryEmpty: begin
        rsp_valid_o = 1'b1;
        rsp_o = '{source_item: src_q, row_degree: 8'd0, has_neighbor: 1'b0,
                  neighbor_item: 8'd0, weight: 16'd0, last: 1'b1};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ict_pkg::StClear;
      clr_q   <= '0;
      len_q   <= ict_pkg::ListLenReset;
      rd_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      rd_v_q  <= rd_v_d;
      if (cfg_valid_i) len_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q <= src_d; usr_q <= usr_d; j_q <= j_d; row_q <= row_d; dir_q <= dir_d;
    deg_q <= deg_d; k_q <= k_d; lim_q <= lim_d; first_q <= first_d;
    found_q <= found_d; oor_q <= oor_d; pc_q <= pc_d; bc_q <= bc_d;
    pj_q <= pj_d; bj_q <= bj_d; rd_j_q <= rd_j_d;
  end

  `ASSERT_NEVER(a_rsp_idle, clk_i, rst_ni, rsp_valid_o && !busy, "result while idle")
  `ASSERT_CLK(a_last_idle, clk_i, rst_ni, rsp_valid_o && rsp_o.last |=> !busy,
              "not idle after last result")
  `ASSERT_NEVER(a_wr_clear, clk_i, rst_ni, c_we && state_q == ict_pkg::StQryScan,
                "count write during query")
endmodule
`default_nettype wire
